FILE: hdl/stbs_pkg.sv
`timescale 1ns / 1ps
package stbs_pkg;

	localparam int DEPTH_DEF = 1024;
	localparam int DATA_WIDTH_DEF = 32;

	localparam int OPCODE_W = 2;
	localparam int WIDX_W = 10;
	localparam int VALUE_W = 32;
	localparam int COUNT_W = 11;
	localparam int RES_W = 12;
	// wide enough for any index or depth in the parameter range
	localparam int IDX_W = 17;

	localparam int S_DATA_W = 48;
	localparam int M_DATA_W = 16;

	localparam logic [OPCODE_W-1:0] OP_WRITE = 2'd0;
	localparam logic [OPCODE_W-1:0] OP_EXACT = 2'd1;
	localparam logic [OPCODE_W-1:0] OP_FIRST = 2'd2;
	localparam logic [OPCODE_W-1:0] OP_LAST  = 2'd3;

	localparam int STATE_W = 2;
	localparam logic [STATE_W-1:0] ST_IDLE  = 2'd0;
	localparam logic [STATE_W-1:0] ST_CHECK = 2'd1;
	localparam logic [STATE_W-1:0] ST_CMP   = 2'd2;
	localparam logic [STATE_W-1:0] ST_FIN   = 2'd3;

	typedef struct packed {
		logic write;
		logic load;
		logic probe;
		logic step;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic in_range;
		logic hit;
	} sts_t;

endpackage

FILE: hdl/stbs_ctrl.sv
`timescale 1ns / 1ps
module stbs_ctrl (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic                            op_write,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	input  stbs_pkg::sts_t                  sts,
	output stbs_pkg::cmd_t                  cmd,
	output logic [stbs_pkg::STATE_W-1:0]    state
);

	logic [stbs_pkg::STATE_W-1:0] state_q;
	logic [stbs_pkg::STATE_W-1:0] state_nxt;
	logic                         m_tvalid_q;

	always_comb begin
		cmd = '0;
		s_tready = 1'b0;
		state_nxt = state_q;
		case (state_q)
			stbs_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					if (op_write) begin
						cmd.write = 1'b1;
					end else begin
						cmd.load = 1'b1;
						state_nxt = stbs_pkg::ST_CHECK;
					end
				end
			end
			stbs_pkg::ST_CHECK: begin
				if (sts.in_range) begin
					cmd.probe = 1'b1;
					state_nxt = stbs_pkg::ST_CMP;
				end else begin
					state_nxt = stbs_pkg::ST_FIN;
				end
			end
			stbs_pkg::ST_CMP: begin
				cmd.step = 1'b1;
				state_nxt = sts.hit ? stbs_pkg::ST_FIN : stbs_pkg::ST_CHECK;
			end
			stbs_pkg::ST_FIN: begin
				// wait for the output register to free up
				if (!m_tvalid_q || m_tready) begin
					cmd.emit = 1'b1;
					state_nxt = stbs_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nxt = stbs_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= stbs_pkg::ST_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.emit) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign state = state_q;

endmodule

FILE: hdl/stbs_dp.sv
`timescale 1ns / 1ps
module stbs_dp #(
	parameter int DEPTH = stbs_pkg::DEPTH_DEF,
	parameter int DATA_WIDTH = stbs_pkg::DATA_WIDTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [stbs_pkg::COUNT_W-1:0]        cfg_data,
	input  logic [stbs_pkg::OPCODE_W-1:0]       opcode,
	input  logic [stbs_pkg::WIDX_W-1:0]         write_index,
	input  logic signed [stbs_pkg::VALUE_W-1:0] value,
	input  stbs_pkg::cmd_t                      cmd,
	output stbs_pkg::sts_t                      sts,
	output logic signed [stbs_pkg::RES_W-1:0]   result_index
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic signed [DATA_WIDTH-1:0]        mem [DEPTH];
	logic signed [DATA_WIDTH-1:0]        rdata_q;
	logic [stbs_pkg::COUNT_W-1:0]        count_q;
	logic [stbs_pkg::OPCODE_W-1:0]       op_q;
	logic signed [DATA_WIDTH-1:0]        key_q;
	logic signed [stbs_pkg::RES_W-1:0]   lo_q;
	logic signed [stbs_pkg::RES_W-1:0]   hi_q;
	logic signed [stbs_pkg::RES_W-1:0]   mid_q;
	logic signed [stbs_pkg::RES_W-1:0]   res_q;
	logic                                found_q;

	logic signed [63:0]                  value_ext;
	logic signed [DATA_WIDTH-1:0]        key_in;
	logic [stbs_pkg::IDX_W-1:0]          widx_wide;
	logic [stbs_pkg::IDX_W-1:0]          mid_wide;
	logic signed [stbs_pkg::RES_W-1:0]   mid;
	logic signed [stbs_pkg::RES_W-1:0]   cnt_active;
	logic                                go_right;

	// only the low DATA_WIDTH bits of the target take part, read as signed
	assign value_ext = 64'(value);
	assign key_in = value_ext[DATA_WIDTH-1:0];
	assign widx_wide = stbs_pkg::IDX_W'(write_index);

	// overflow-safe midpoint
	assign mid = lo_q + ((hi_q - lo_q) >>> 1);
	assign mid_wide = stbs_pkg::IDX_W'($unsigned(mid));

	assign cnt_active = (stbs_pkg::IDX_W'(count_q) > stbs_pkg::IDX_W'(DEPTH)) ?
		stbs_pkg::RES_W'(DEPTH) : stbs_pkg::RES_W'(count_q);

	assign sts.in_range = (lo_q <= hi_q);
	assign sts.hit = (op_q == stbs_pkg::OP_EXACT) && (rdata_q == key_q);

	always_comb begin
		case (op_q)
			stbs_pkg::OP_EXACT: go_right = (rdata_q < key_q);
			stbs_pkg::OP_FIRST: go_right = (rdata_q < key_q);
			stbs_pkg::OP_LAST:  go_right = (rdata_q <= key_q);
			default:            go_right = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.write && (widx_wide < stbs_pkg::IDX_W'(DEPTH))) begin
			mem[widx_wide[AW-1:0]] <= key_in;
		end
		if (cmd.probe) begin
			rdata_q <= mem[mid_wide[AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cfg_we) begin
			count_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= opcode;
			key_q <= key_in;
			lo_q <= '0;
			hi_q <= cnt_active - stbs_pkg::RES_W'(1);
			found_q <= 1'b0;
		end
		if (cmd.probe) begin
			mid_q <= mid;
		end
		if (cmd.step) begin
			if (sts.hit) begin
				found_q <= 1'b1;
			end else if (go_right) begin
				lo_q <= mid_q + stbs_pkg::RES_W'(1);
			end else begin
				hi_q <= mid_q - stbs_pkg::RES_W'(1);
			end
		end
		if (cmd.emit) begin
			case (op_q)
				stbs_pkg::OP_FIRST: res_q <= lo_q;
				stbs_pkg::OP_LAST:  res_q <= hi_q;
				default:            res_q <= found_q ? mid_q : '1;
			endcase
		end
	end

	assign result_index = res_q;

endmodule

FILE: hdl/sorted_table_binary_search.sv
`timescale 1ns / 1ps
// sorted table with binary search
// s_* channel takes items: opcode write loads one table entry and gives no
// result; exact, first-not-less and last-not-greater queries give one result
// item each on the m_* channel, in order of acceptance.
// cfg_* channel sets the number of entries in use and is always ready; the
// user must write it only while no query is in flight, unchecked by the block.
// a write is taken in idle and leaves the block idle. a query runs P probes,
// P <= floor(log2(count)) + 1 (11 at 1024 entries); each probe is one
// registered table read followed by one compare, and an exact search that
// hits goes straight to the finish state. the input is ready only in idle,
// so a query holds it until its result is loaded.
// if the receiver stalls, the result holds in the output register; writes and
// one further query may still be accepted, and that query waits at its end
// until the register is taken.
// reset clears the entry count to zero and empties the output; table
// contents are undefined until written.
module sorted_table_binary_search #(
	parameter int DEPTH = stbs_pkg::DEPTH_DEF,
	parameter int DATA_WIDTH = stbs_pkg::DATA_WIDTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [stbs_pkg::COUNT_W-1:0]       cfg_data,   // element_count
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [stbs_pkg::S_DATA_W-1:0]      s_tdata,    // opcode, write_index, value
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [stbs_pkg::M_DATA_W-1:0]      m_tdata     // result_index
);

	stbs_pkg::cmd_t                    cmd;
	stbs_pkg::sts_t                    sts;
	logic [stbs_pkg::STATE_W-1:0]      state;
	logic [stbs_pkg::OPCODE_W-1:0]     opcode;
	logic [stbs_pkg::WIDX_W-1:0]       write_index;
	logic signed [stbs_pkg::VALUE_W-1:0] value;
	logic signed [stbs_pkg::RES_W-1:0] result_index;

	assign cfg_ready = 1'b1;
	assign opcode = s_tdata[1:0];
	assign write_index = s_tdata[11:2];
	assign value = s_tdata[43:12];
	assign m_tdata = {{(stbs_pkg::M_DATA_W - stbs_pkg::RES_W){1'b0}}, result_index};

	stbs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.op_write (opcode == stbs_pkg::OP_WRITE),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.sts      (sts),
		.cmd      (cmd),
		.state    (state)
	);

	stbs_dp #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_valid && cfg_ready),
		.cfg_data     (cfg_data),
		.opcode       (opcode),
		.write_index  (write_index),
		.value        (value),
		.cmd          (cmd),
		.sts          (sts),
		.result_index (result_index)
	);

	a_query_starts: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (opcode != stbs_pkg::OP_WRITE) |=> state == stbs_pkg::ST_CHECK)
		else $error("query accepted but search did not start");

	a_cmp_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		state == stbs_pkg::ST_CMP |-> $past(state) == stbs_pkg::ST_CHECK)
		else $error("compare without a table read");

	a_result_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state) == stbs_pkg::ST_FIN)
		else $error("result valid outside finish");

	a_write_no_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (opcode == stbs_pkg::OP_WRITE) |=> state == stbs_pkg::ST_IDLE)
		else $error("write item started a search");

endmodule
